// File: src/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, codes and character constants for the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // default depth of the bracket stack
    localparam int STACK_DEPTH_DEF = 32;

    // character codes
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LANGLE  = 8'h3C;
    localparam logic [7:0] CH_RANGLE  = 8'h3E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // bracket kind as held on the stack
    typedef enum logic [1:0] {
        KIND_PAREN = 2'd0,
        KIND_BRACK = 2'd1,
        KIND_BRACE = 2'd2,
        KIND_ANGLE = 2'd3
    } kind_t;

    // line status, also used as the recorded error code
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_UNCLOSED = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // word passed from the stack front end to the verdict stage
    typedef struct packed {
        logic    newline;   // word ends the line
        logic    check;     // closer whose top-of-stack read must be compared
        kind_t   kind;      // kind the closer expects
        status_t event_st;  // error found from the stack level alone
        logic    open_left; // stack not empty when the newline arrived
    } item_t;

endpackage

// File: src/bbc_ram.sv
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front
// Character decode, stack level tracking and stack memory access. The level
// runs ahead on the assumption that closers match; the verdict stage checks.
// ----------------------------------------------------------------------------
module bbc_front #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   accept,
    input  logic [7:0]                                             char_byte,
    output logic                                                   ram_we,
    output logic [$clog2(STACK_DEPTH > 1 ? STACK_DEPTH : 2)-1:0]   ram_waddr,
    output bbc_pkg::kind_t                                         ram_wdata,
    output logic                                                   ram_re,
    output logic [$clog2(STACK_DEPTH > 1 ? STACK_DEPTH : 2)-1:0]   ram_raddr,
    output bbc_pkg::item_t                                         item
);
    import bbc_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH > 1 ? STACK_DEPTH : 2);
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic [LVL_W-1:0] level_dec;
    logic             is_open;
    logic             is_close;
    logic             is_newline;
    kind_t            kind;
    logic             full;
    logic             empty;

    // character decoder
    always_comb
    begin
        is_open    = 1'b0;
        is_close   = 1'b0;
        is_newline = 1'b0;
        kind       = KIND_PAREN;
        unique case (char_byte)
            CH_LPAREN:  begin is_open  = 1'b1; kind = KIND_PAREN; end
            CH_LBRACK:  begin is_open  = 1'b1; kind = KIND_BRACK; end
            CH_LBRACE:  begin is_open  = 1'b1; kind = KIND_BRACE; end
            CH_LANGLE:  begin is_open  = 1'b1; kind = KIND_ANGLE; end
            CH_RPAREN:  begin is_close = 1'b1; kind = KIND_PAREN; end
            CH_RBRACK:  begin is_close = 1'b1; kind = KIND_BRACK; end
            CH_RBRACE:  begin is_close = 1'b1; kind = KIND_BRACE; end
            CH_RANGLE:  begin is_close = 1'b1; kind = KIND_ANGLE; end
            CH_NEWLINE: is_newline = 1'b1;
            default:    ;
        endcase
    end

    assign full      = (level_reg == LVL_W'(STACK_DEPTH));
    assign empty     = (level_reg == '0);
    assign level_dec = level_reg - LVL_W'(1);

    // memory access: push writes at the level, closer reads the top
    assign ram_we    = accept && is_open && !full;
    assign ram_waddr = level_reg[ADDR_W-1:0];
    assign ram_wdata = kind;
    assign ram_re    = accept && is_close && !empty;
    assign ram_raddr = level_dec[ADDR_W-1:0];

    // stack level update
    always_comb
    begin
        level_next = level_reg;
        if (accept)
        begin
            if (is_newline)
            begin
                level_next = '0;
            end
            else if (is_open && !full)
            begin
                level_next = level_reg + LVL_W'(1);
            end
            else if (is_close && !empty)
            begin
                level_next = level_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    // word for the verdict stage
    always_comb
    begin
        item.newline   = is_newline;
        item.check     = is_close && !empty;
        item.kind      = kind;
        item.open_left = !empty;
        if (is_open && full)
        begin
            item.event_st = ST_OVERFLOW;
        end
        else if (is_close && empty)
        begin
            item.event_st = ST_MISMATCH;
        end
        else
        begin
            item.event_st = ST_OK;
        end
    end

endmodule

// File: src/bbc_verdict.sv
// ----------------------------------------------------------------------------
// bbc_verdict
// Compares closers against the top-of-stack read, keeps the first error of
// the line and builds the verdict word in the output register.
// ----------------------------------------------------------------------------
module bbc_verdict (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bbc_pkg::item_t    item_in,
    input  bbc_pkg::kind_t    top_kind,
    output logic              take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              balanced,
    output bbc_pkg::status_t  status
);
    import bbc_pkg::*;

    logic    s2_valid_reg;
    logic    s2_valid_next;
    item_t   item_reg;
    status_t err_reg;
    status_t err_next;
    status_t err_upd;
    status_t verdict;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    balanced_reg;
    status_t status_reg;
    logic    slot_free;
    logic    adv;

    // stage handshake
    assign slot_free = !out_valid_reg || out_ready;
    assign adv       = s2_valid_reg && (!item_reg.newline || slot_free);
    assign take      = !s2_valid_reg || adv;

    // first error of the line wins
    always_comb
    begin
        if (err_reg != ST_OK)
        begin
            err_upd = err_reg;
        end
        else if (item_reg.event_st != ST_OK)
        begin
            err_upd = item_reg.event_st;
        end
        else if (item_reg.check && (top_kind != item_reg.kind))
        begin
            err_upd = ST_MISMATCH;
        end
        else
        begin
            err_upd = ST_OK;
        end
    end

    assign verdict = (err_upd != ST_OK) ? err_upd :
                     (item_reg.open_left ? ST_UNCLOSED : ST_OK);

    always_comb
    begin
        err_next = err_reg;
        if (adv)
        begin
            err_next = item_reg.newline ? ST_OK : err_upd;
        end
    end

    assign s2_valid_next = load ? 1'b1 : (adv ? 1'b0 : s2_valid_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && item_reg.newline)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
        if (adv && item_reg.newline)
        begin
            balanced_reg <= (verdict == ST_OK);
            status_reg   <= verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign balanced  = balanced_reg;
    assign status    = status_reg;

    // the recorded error is never the unclosed code
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_UNCLOSED)
        else $error("error register holds unclosed code");

    // a retired newline always shows a verdict next cycle
    a_verdict_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && item_reg.newline) |=> out_valid_reg)
        else $error("newline retired without verdict");

    // balanced flag agrees with the status code
    a_bal_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (balanced_reg == (status_reg == ST_OK)))
        else $error("balanced flag disagrees with status");

    // the stage only blocks behind a waiting verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !take |-> (s2_valid_reg && item_reg.newline && out_valid_reg && !out_ready))
        else $error("stage stalled without cause");

endmodule

// File: src/bracket_balance_checker.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Per-line bracket balance check over a byte stream, one verdict per newline.
// ----------------------------------------------------------------------------
// Accepts one character word per clock cycle and returns one verdict word
// (balanced flag and status) for each newline, registered once the newline has
// passed the verdict stage. The bracket stack lives in a synchronous RAM: pushes
// write at the current level, closers issue a read of the top entry on
// acceptance and the kind is compared in the next cycle in the verdict stage.
// The input stalls only while a newline waits behind a verdict that has not
// been taken; otherwise throughput is one byte per cycle. Stack deeper than
// STACK_DEPTH reports overflow. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              balanced,
    output logic [1:0]        status
);
    import bbc_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH > 1 ? STACK_DEPTH : 2);

    logic              accept;
    logic              take;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    kind_t             ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [1:0]        ram_rdata;
    item_t             item;
    status_t           status_st;

    assign in_ready = take;
    assign accept   = in_valid && take;

    // level tracking and stack access
    bbc_front #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_byte (char_byte),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .item      (item)
    );

    // bracket kind stack
    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // compare and verdict
    bbc_verdict u_verdict (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .item_in   (item),
        .top_kind  (kind_t'(ram_rdata)),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .balanced  (balanced),
        .status    (status_st)
    );

    assign status = status_st;

endmodule

// File: tb/tb_bracket_balance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bracket_balance_checker
// Self-checking testbench for the per-line bracket balance checker.
// ----------------------------------------------------------------------------
// Character words go in through a valid/ready driver, and a line model
// predicts one verdict for each newline. A scoreboard matches every verdict
// taken from the block against the oldest prediction. A short directed
// sequence comes first. Random lines follow: balanced, nested to full depth,
// overflowing, mismatched, unclosed, noise and empty. The random lines run in
// four idling phases on the input and output sides.
// ----------------------------------------------------------------------------
module tb_bracket_balance_checker;

    import bbc_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int PHASE_CHARS = 175;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 16;

    // shapes of generated lines
    typedef enum int {
        LINE_BALANCED,
        LINE_FULL,
        LINE_OVERFLOW,
        LINE_MISMATCH,
        LINE_UNCLOSED,
        LINE_NOISE,
        LINE_EMPTY
    } line_shape_t;

    typedef struct packed {
        logic    balanced;
        status_t status;
    } verdict_t;

    // line model and queue of verdicts still owed by the block
    class verdict_board;
        kind_t    open_kinds[DEPTH];
        int       depth_now;
        status_t  line_err;
        verdict_t owed[$];
        int       errors;

        function new();
            depth_now = 0;
            line_err  = ST_OK;
            errors    = 0;
        endfunction

        function void note_char(logic [7:0] c);
            verdict_t v;
            kind_t    k;
            bit       is_open;
            bit       is_close;
            case (c)
                CH_LPAREN, CH_RPAREN: k = KIND_PAREN;
                CH_LBRACK, CH_RBRACK: k = KIND_BRACK;
                CH_LBRACE, CH_RBRACE: k = KIND_BRACE;
                default:              k = KIND_ANGLE;
            endcase
            is_open  = (c == CH_LPAREN) || (c == CH_LBRACK) ||
                       (c == CH_LBRACE) || (c == CH_LANGLE);
            is_close = (c == CH_RPAREN) || (c == CH_RBRACK) ||
                       (c == CH_RBRACE) || (c == CH_RANGLE);
            if (c == CH_NEWLINE)
            begin
                // recorded error first, then open brackets, else balanced
                if (line_err != ST_OK)
                    v.status = line_err;
                else if (depth_now != 0)
                    v.status = ST_UNCLOSED;
                else
                    v.status = ST_OK;
                v.balanced = (v.status == ST_OK);
                owed.push_back(v);
                depth_now = 0;
                line_err  = ST_OK;
            end
            else if (line_err == ST_OK)
            begin
                if (is_open)
                begin
                    if (depth_now < DEPTH)
                    begin
                        open_kinds[depth_now] = k;
                        depth_now++;
                    end
                    else
                        line_err = ST_OVERFLOW;
                end
                else if (is_close)
                begin
                    if (depth_now == 0 || open_kinds[depth_now - 1] != k)
                        line_err = ST_MISMATCH;
                    else
                        depth_now--;
                end
            end
        endfunction

        function void check_verdict(logic bal, logic [1:0] st);
            verdict_t v;
            if (owed.size() == 0)
            begin
                $display("%0t: verdict with none owed, got balanced=%0b status=%0d",
                         $time, bal, st);
                errors++;
            end
            else
            begin
                v = owed.pop_front();
                if (bal !== v.balanced)
                begin
                    $display("%0t: balanced mismatch, expected %0b, got %0b",
                             $time, v.balanced, bal);
                    errors++;
                end
                if (st !== v.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, v.status, st);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] char_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       balanced;
    logic [1:0] status;

    verdict_board board;
    logic [7:0]   line_chars[$];
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           idle_cycles    = 0;

    bracket_balance_checker #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .char_byte(char_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .balanced (balanced),
        .status   (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // verdict side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // take verdict words
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_verdict(balanced, status);
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_bracket_balance_checker failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] opener_of(kind_t k);
        case (k)
            KIND_PAREN: return CH_LPAREN;
            KIND_BRACK: return CH_LBRACK;
            KIND_BRACE: return CH_LBRACE;
            default:    return CH_LANGLE;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(kind_t k);
        case (k)
            KIND_PAREN: return CH_RPAREN;
            KIND_BRACK: return CH_RBRACK;
            KIND_BRACE: return CH_RBRACE;
            default:    return CH_RANGLE;
        endcase
    endfunction

    // any byte that neither ends the line nor is a bracket
    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_NEWLINE || c == CH_LPAREN || c == CH_RPAREN ||
               c == CH_LBRACK || c == CH_RBRACK || c == CH_LBRACE ||
               c == CH_RBRACE || c == CH_LANGLE || c == CH_RANGLE);
        return c;
    endfunction

    // any byte except newline
    function automatic logic [7:0] line_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_NEWLINE);
        return c;
    endfunction

    // offer one character word and wait until it is taken
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_char(c);
    endtask

    // send the collected line followed by its newline
    task automatic send_line(inout int sent);
        foreach (line_chars[i])
            send_char(line_chars[i]);
        send_char(CH_NEWLINE);
        sent += line_chars.size() + 1;
        line_chars.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_chars.push_back(s[i]);
    endtask

    task automatic build_line(input line_shape_t shape);
        kind_t opened[$];
        kind_t k;
        int    r;
        int    n;
        case (shape)
            LINE_FULL, LINE_OVERFLOW:
            begin
                // nest right up to the stack depth, or past it
                n = (shape == LINE_FULL) ? $urandom_range(DEPTH - 1, DEPTH)
                                         : $urandom_range(DEPTH + 1, DEPTH + 3);
                repeat (n)
                begin
                    k = kind_t'($urandom_range(0, 3));
                    opened.push_back(k);
                    line_chars.push_back(opener_of(k));
                end
                if (shape == LINE_FULL)
                begin
                    while (opened.size() > 0)
                        line_chars.push_back(closer_of(opened.pop_back()));
                end
                else
                begin
                    // everything after the overflow is skipped
                    repeat ($urandom_range(0, 4))
                        line_chars.push_back(closer_of(opened.pop_back()));
                    repeat ($urandom_range(0, 3))
                        line_chars.push_back(line_byte());
                end
            end
            LINE_NOISE:
                repeat ($urandom_range(0, 12))
                    line_chars.push_back(line_byte());
            LINE_EMPTY:
                ;
            default:
            begin
                // random walk of openers, matched closers and filler
                repeat ($urandom_range(1, 14))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40 && opened.size() < 6)
                    begin
                        k = kind_t'($urandom_range(0, 3));
                        opened.push_back(k);
                        line_chars.push_back(opener_of(k));
                    end
                    else if (r < 75 && opened.size() > 0)
                        line_chars.push_back(closer_of(opened.pop_back()));
                    else
                        line_chars.push_back(filler_char());
                end
                if (shape == LINE_BALANCED)
                begin
                    while (opened.size() > 0)
                        line_chars.push_back(closer_of(opened.pop_back()));
                end
                else if (shape == LINE_UNCLOSED)
                begin
                    if (opened.size() == 0)
                        line_chars.push_back(opener_of(kind_t'($urandom_range(0, 3))));
                end
                else
                begin
                    // sometimes empty the stack first so the closer is unopened
                    if ($urandom_range(0, 2) == 0)
                    begin
                        while (opened.size() > 0)
                            line_chars.push_back(closer_of(opened.pop_back()));
                    end
                    if (opened.size() == 0)
                        k = kind_t'($urandom_range(0, 3));
                    else
                        k = kind_t'((int'(opened[$]) + $urandom_range(1, 3)) % 4);
                    line_chars.push_back(closer_of(k));
                    // trailing bytes are skipped
                    repeat ($urandom_range(0, 6))
                        line_chars.push_back(line_byte());
                end
            end
        endcase
    endtask

    function automatic line_shape_t pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return LINE_BALANCED;
        else if (r < 46)
            return LINE_FULL;
        else if (r < 52)
            return LINE_OVERFLOW;
        else if (r < 66)
            return LINE_MISMATCH;
        else if (r < 78)
            return LINE_UNCLOSED;
        else if (r < 94)
            return LINE_NOISE;
        else
            return LINE_EMPTY;
    endfunction

    // stimulus and end of run
    initial
    begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        int sent;
        int lines;
        idle_by_phase  = '{0, 73, 0, 22};
        stall_by_phase = '{0, 0, 73, 22};
        board = new();
        sent  = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines: empty, all kinds nested, unopened closer,
        // wrong kind with skipped tail, unclosed, extreme filler bytes
        send_line(sent);
        add_text("([{<>}])");
        send_line(sent);
        add_text(")");
        send_line(sent);
        add_text("(]x)");
        send_line(sent);
        add_text("{<");
        send_line(sent);
        line_chars.push_back(8'h00);
        line_chars.push_back(8'hFF);
        send_line(sent);

        // random lines under each idling phase
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            sent  = 0;
            lines = 0;
            while (sent < PHASE_CHARS || lines < 12)
            begin
                if (lines == 0)
                    build_line(LINE_OVERFLOW);
                else if (lines == 1)
                    build_line(LINE_FULL);
                else
                    build_line(pick_shape());
                send_line(sent);
                lines++;
            end
        end
        in_valid <= 1'b0;

        // drain outstanding verdicts
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (board.errors == 0)
            $display("tb_bracket_balance_checker passed");
        else
            $display("tb_bracket_balance_checker failed");
        $finish;
    end

endmodule
